@@ design/tfm_pkg.sv @@
package tfm_pkg;

    // field and register widths
    localparam int unsigned DW        = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // divider: 16 quotient bits from a 32-bit dividend, one bit a cycle
    localparam int unsigned DIV_STEPS = DW;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BW_RISE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BW_FALL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DIVISOR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_KIND = 3'd6;

    // response kinds
    localparam logic RESP_LINEAR = 1'b0;
    localparam logic RESP_STEP   = 1'b1;

    // reset values of the registers
    localparam logic [DW-1:0] RST_BW_RISE      = 16'd16;
    localparam logic [DW-1:0] RST_BW_FALL      = 16'd16;
    localparam logic [DW-1:0] RST_ZERO_OFFSET  = 16'd0;
    localparam logic [DW-1:0] RST_FULL_SCALE   = 16'hFFFF;
    localparam logic [DW-1:0] RST_GAIN         = 16'd1;
    localparam logic [DW-1:0] RST_GAIN_DIVISOR = 16'd1;

    // value limits
    localparam logic [DW-1:0] INVALID_SAMPLE = 16'hFFFF;
    localparam logic [DW-1:0] U16_TOP        = 16'hFFFF;
    localparam logic [DW-1:0] S16_TOP        = 16'h7FFF;
    localparam logic [DW-1:0] S16_BOTTOM     = 16'h8000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;      // capture the accepted sample
        logic filt;      // start the filter division
        logic avg_load;  // store the new average
        logic scale;     // start the scaling division
        logic x_direct;  // store the scaled level without dividing
        logic x_load;    // store the scaled level from the divider
        logic map;       // start the mapping division
        logic out_load;  // fill the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic filt_skip;     // failed conversion, average holds
        logic scale_direct;  // scaled level known without dividing
        logic div_done;      // divider result ready
        logic div_busy;      // divider iterating
    } t_status;

endpackage

@@ design/tfm_div.sv @@
module tfm_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2*tfm_pkg::DW-1:0] i_dividend,
    input  logic [tfm_pkg::DW-1:0]   i_divisor,
    output logic [tfm_pkg::DW-1:0]   o_quot,
    output logic                     o_ovf,
    output logic                     o_done,
    output logic                     o_busy
);
    import tfm_pkg::*;

    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_lo;
    logic [DW-1:0]        r_dvs;
    logic [DW-1:0]        r_quot;
    logic                 r_ovf;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    logic        last;

    // one restoring step: bring down the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_lo[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = trial >= {1'b0, r_dvs};
        last  = r_cnt == DIV_CNT_W'(DIV_STEPS - 1);
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder, dividend bits and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*DW-1:DW];
            r_lo  <= i_dividend[DW-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // quotient does not fit in 16 bits when the upper half already reaches the divisor
            if (r_cnt == '0) begin
                r_ovf <= r_rem >= r_dvs;
            end
            r_rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_lo   <= {r_lo[DW-2:0], 1'b0};
            r_quot <= {r_quot[DW-2:0], ge};
        end
    end

    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;
    assign o_done = r_done;
    assign o_busy = r_busy;

endmodule

@@ design/tfm_dp.sv @@
module tfm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [tfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tfm_pkg::DW-1:0]        i_cfg_data,
    input  logic [tfm_pkg::DW-1:0]        i_sample,
    input  tfm_pkg::t_cmd                 i_cmd,
    output tfm_pkg::t_status              o_status,
    output logic [tfm_pkg::DW-1:0]        o_average,
    output logic signed [tfm_pkg::DW-1:0] o_current_ref
);
    import tfm_pkg::*;

    // configuration registers
    logic [DW-1:0]        r_bw_rise;
    logic [DW-1:0]        r_bw_fall;
    logic [DW-1:0]        r_zero_offset;
    logic [DW-1:0]        r_full_scale;
    logic signed [DW-1:0] r_gain;
    logic [DW-1:0]        r_gain_divisor;
    logic                 r_response_kind;

    // working registers
    logic [DW-1:0]        r_sample;
    logic [DW-1:0]        r_avg;
    logic [DW-1:0]        r_x;
    logic [DW-1:0]        r_average;
    logic [DW-1:0]        r_current_ref;

    logic [DW-1:0]   bw_sel;
    logic [DW-1:0]   bw_eff;
    logic [DW-1:0]   gain_mag;
    logic [DW-1:0]   gdiv_eff;
    logic [DW-1:0]   mul_a;
    logic [DW-1:0]   mul_b;
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] acc;
    logic            lvl_zero;
    logic [DW-1:0]   lvl;
    logic [2*DW-1:0] scl_dvd;
    logic            div_start;
    logic [2*DW-1:0] div_dvd;
    logic [DW-1:0]   div_dvs;
    logic [DW-1:0]   div_quot;
    logic            div_ovf;
    logic            div_done;
    logic            div_busy;
    logic [DW-1:0]   cur;

    // register writes, ready is always high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw_rise       <= RST_BW_RISE;
            r_bw_fall       <= RST_BW_FALL;
            r_zero_offset   <= RST_ZERO_OFFSET;
            r_full_scale    <= RST_FULL_SCALE;
            r_gain          <= RST_GAIN;
            r_gain_divisor  <= RST_GAIN_DIVISOR;
            r_response_kind <= RESP_LINEAR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BW_RISE:       r_bw_rise       <= i_cfg_data;
                CFG_BW_FALL:       r_bw_fall       <= i_cfg_data;
                CFG_ZERO_OFFSET:   r_zero_offset   <= i_cfg_data;
                CFG_FULL_SCALE:    r_full_scale    <= i_cfg_data;
                CFG_GAIN:          r_gain          <= i_cfg_data;
                CFG_GAIN_DIVISOR:  r_gain_divisor  <= i_cfg_data;
                CFG_RESPONSE_KIND: r_response_kind <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // operand selection, zero divisors act as one
    always_comb begin
        bw_sel   = (r_sample > r_avg) ? r_bw_rise : r_bw_fall;
        bw_eff   = (bw_sel == '0) ? DW'(1) : bw_sel;
        gdiv_eff = (r_gain_divisor == '0) ? DW'(1) : r_gain_divisor;
        gain_mag = r_gain[DW-1] ? DW'(-r_gain) : DW'(r_gain);
    end

    // shared 16x16 multiplier: filter weight or mapping gain
    always_comb begin
        mul_a = i_cmd.filt ? (bw_eff - DW'(1)) : gain_mag;
        if (i_cmd.filt) begin
            mul_b = r_avg;
        end else if (r_response_kind == RESP_STEP) begin
            mul_b = S16_TOP;
        end else begin
            mul_b = r_x;
        end
        prod = {{DW{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};
        acc  = prod + {{DW{1'b0}}, r_sample};
    end

    // offset removal, level times 65535 as a shift and subtract
    always_comb begin
        lvl_zero = r_avg <= r_zero_offset;
        lvl      = r_avg - r_zero_offset;
        scl_dvd  = {lvl, {DW{1'b0}}} - {{DW{1'b0}}, lvl};
    end

    // divider source selection
    always_comb begin
        div_start = i_cmd.filt | i_cmd.scale | i_cmd.map;
        if (i_cmd.filt) begin
            div_dvd = acc;
            div_dvs = bw_eff;
        end else if (i_cmd.scale) begin
            div_dvd = scl_dvd;
            div_dvs = r_full_scale;
        end else begin
            div_dvd = prod;
            div_dvs = gdiv_eff;
        end
    end

    tfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quot     (div_quot),
        .o_ovf      (div_ovf),
        .o_done     (div_done),
        .o_busy     (div_busy)
    );

    // current reference from the magnitude quotient and the gain sign
    always_comb begin
        if (r_response_kind == RESP_STEP) begin
            if (r_gain[DW-1]) begin
                cur = S16_TOP;
            end else if (div_ovf || (r_x < div_quot)) begin
                cur = '0;
            end else begin
                cur = S16_TOP;
            end
        end else if (r_gain[DW-1]) begin
            cur = (div_ovf || (div_quot > S16_BOTTOM)) ? S16_BOTTOM : DW'(-div_quot);
        end else begin
            cur = (div_ovf || (div_quot > S16_TOP)) ? S16_TOP : div_quot;
        end
    end

    // running average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (i_cmd.avg_load) begin
            r_avg <= div_quot;
        end
    end

    // sample, scaled level and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
        end
        if (i_cmd.x_direct) begin
            r_x <= lvl_zero ? '0 : U16_TOP;
        end else if (i_cmd.x_load) begin
            r_x <= div_ovf ? U16_TOP : div_quot;
        end
        if (i_cmd.out_load) begin
            r_average     <= r_avg;
            r_current_ref <= cur;
        end
    end

    always_comb begin
        o_status.filt_skip    = r_sample == INVALID_SAMPLE;
        o_status.scale_direct = lvl_zero || (r_full_scale == '0);
        o_status.div_done     = div_done;
        o_status.div_busy     = div_busy;
    end

    assign o_average     = r_average;
    assign o_current_ref = r_current_ref;

endmodule

@@ design/tfm_ctrl.sv @@
module tfm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    input  tfm_pkg::t_status i_status,
    output tfm_pkg::t_cmd    o_cmd
);
    import tfm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_FDIV,
        S_SCALE,
        S_SDIV,
        S_MAP,
        S_MDIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_FILT;
                end
            end
            S_FILT: begin
                if (i_status.filt_skip) begin
                    n_state = S_SCALE;
                end else begin
                    o_cmd.filt = 1'b1;
                    n_state    = S_FDIV;
                end
            end
            S_FDIV: begin
                if (i_status.div_done) begin
                    o_cmd.avg_load = 1'b1;
                    n_state        = S_SCALE;
                end
            end
            S_SCALE: begin
                if (i_status.scale_direct) begin
                    o_cmd.x_direct = 1'b1;
                    n_state        = S_MAP;
                end else begin
                    o_cmd.scale = 1'b1;
                    n_state     = S_SDIV;
                end
            end
            S_SDIV: begin
                if (i_status.div_done) begin
                    o_cmd.x_load = 1'b1;
                    n_state      = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_MDIV;
            end
            S_MDIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output transaction valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

@@ design/throttle_filter_torque_map.sv @@
// Throttle filter and torque map. Each input transaction carries one raw throttle
// conversion; each produces exactly one output transaction with the filtered average
// and the signed torque current reference. One item is worked on at a time: the block
// takes the next sample only once the previous result is in the output register. The
// filter division is skipped when the sample is a failed conversion, and the scaling
// division when the offset-removed level is zero or full_scale is zero. Each item makes
// up to three passes through the single shared divider, which produces one quotient bit
// per cycle (16 steps). A finished result waits in the output register while
// the next sample is taken and processed. Configuration writes are always ready and
// must only be issued while the block is idle.
module throttle_filter_torque_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tfm_pkg::DW-1:0]        i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tfm_pkg::DW-1:0]        o_average,
    output logic signed [tfm_pkg::DW-1:0] o_current_ref,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tfm_pkg::DW-1:0]        i_cfg_data
);
    import tfm_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    tfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // filter, scaling and mapping datapath
    tfm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_average     (o_average),
        .o_current_ref (o_current_ref)
    );

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but block not busy afterwards");

    // the divider only finishes while an item is in progress
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.div_done |-> o_in_stall)
        else $error("divider result with no item in progress");

    // a division is never started over one still iterating
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.filt || cmd.scale || cmd.map) |-> !status.div_busy)
        else $error("divider restarted while busy");

    // the output register is filled only when free, and then shows valid
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall) ##1 o_out_valid)
        else $error("output register overwritten or not shown");

endmodule

@@ tb/throttle_filter_torque_map_tb.sv @@
module throttle_filter_torque_map_tb;
    import tfm_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned SETTLE_CYCLES   = 64;
    localparam int unsigned RANDOM_PHASES   = 16;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned HOLD_CYCLES     = 600;
    localparam int unsigned REPORT_LIMIT    = 10;

    // one full set of the block's registers
    typedef struct {
        logic [DW-1:0]        bw_rise;
        logic [DW-1:0]        bw_fall;
        logic [DW-1:0]        zero_offset;
        logic [DW-1:0]        full_scale;
        logic signed [DW-1:0] gain;
        logic [DW-1:0]        gain_divisor;
        logic                 response_kind;
    } t_map_settings;

    // fields of one output transaction
    typedef struct {
        logic [DW-1:0]        average;
        logic signed [DW-1:0] current_ref;
    } t_map_output;

    // filter and torque map predictor plus the queue of awaited outputs
    class torque_map_scoreboard;
        t_map_settings regs;
        logic [DW-1:0] avg_level;
        t_map_output   awaited[$];
        int unsigned   samples_seen;
        int unsigned   failed_convs;
        int unsigned   results_checked;
        int unsigned   mismatches;

        function new();
            regs.bw_rise       = RST_BW_RISE;
            regs.bw_fall       = RST_BW_FALL;
            regs.zero_offset   = RST_ZERO_OFFSET;
            regs.full_scale    = RST_FULL_SCALE;
            regs.gain          = RST_GAIN;
            regs.gain_divisor  = RST_GAIN_DIVISOR;
            regs.response_kind = RESP_LINEAR;
            avg_level          = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
            case (idx)
                CFG_BW_RISE:       regs.bw_rise = data;
                CFG_BW_FALL:       regs.bw_fall = data;
                CFG_ZERO_OFFSET:   regs.zero_offset = data;
                CFG_FULL_SCALE:    regs.full_scale = data;
                CFG_GAIN:          regs.gain = data;
                CFG_GAIN_DIVISOR:  regs.gain_divisor = data;
                CFG_RESPONSE_KIND: regs.response_kind = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // accepted input transaction: advance the average and predict the output
        function void take_sample(logic [DW-1:0] raw);
            logic [DW-1:0] bw;
            logic [31:0]   acc;
            logic [31:0]   quo;
            logic [DW-1:0] level;
            longint        div;
            longint        val;
            t_map_output   predicted;
            samples_seen++;
            // asymmetric low pass, failed conversions hold the average
            bw = (raw > avg_level) ? regs.bw_rise : regs.bw_fall;
            if (raw == INVALID_SAMPLE) begin
                failed_convs++;
            end else begin
                if (bw == '0) bw = 16'd1;
                acc = ({16'd0, bw} - 32'd1) * {16'd0, avg_level} + {16'd0, raw};
                quo = acc / {16'd0, bw};
                avg_level = quo[DW-1:0];
            end
            // offset removal and scaling to the full 16-bit span
            if (avg_level <= regs.zero_offset) begin
                level = '0;
            end else if (regs.full_scale == '0) begin
                level = U16_TOP;
            end else begin
                quo = (32'h0000FFFF * {16'd0, avg_level - regs.zero_offset})
                      / {16'd0, regs.full_scale};
                level = (quo > 32'h0000FFFF) ? U16_TOP : quo[DW-1:0];
            end
            // linear or step torque map
            if (regs.gain_divisor == '0) div = 1;
            else div = longint'({48'd0, regs.gain_divisor});
            if (regs.response_kind == RESP_LINEAR) begin
                val = longint'(regs.gain) * longint'({48'd0, level}) / div;
                if (val > 32767) val = 32767;
                else if (val < -32768) val = -32768;
                predicted.current_ref = val[DW-1:0];
            end else begin
                val = longint'(regs.gain) * 64'sd32767 / div;
                predicted.current_ref = (longint'({48'd0, level}) < val) ? '0 : S16_TOP;
            end
            predicted.average = avg_level;
            awaited.push_back(predicted);
        endfunction

        // accepted output transaction against the oldest prediction
        function void check_output(logic [DW-1:0] avg, logic signed [DW-1:0] cur);
            t_map_output want;
            results_checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: average %0d current_ref %0d", avg, cur);
                return;
            end
            want = awaited.pop_front();
            if (want.average !== avg || want.current_ref !== cur) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: average exp %0d got %0d, current_ref exp %0d got %0d",
                             want.average, avg, want.current_ref, cur);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [DW-1:0]         i_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DW-1:0]         o_average;
    logic signed [DW-1:0]  o_current_ref;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DW-1:0]         i_cfg_data = '0;

    torque_map_scoreboard board = new();
    int unsigned   in_idle_pct = 0;
    int unsigned   out_stall_pct = 0;
    logic          out_hold = 1'b0;
    int unsigned   cycle_count = 0;
    int unsigned   settings_used = 0;
    logic [DW-1:0] level_target = 16'h8000;

    throttle_filter_torque_map i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_average     (o_average),
        .o_current_ref (o_current_ref),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall, random plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= out_hold || ($urandom_range(0, 99) < out_stall_pct);
    end

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.take_sample(i_sample);
            if (o_out_valid && !i_out_stall) board.check_output(o_average, o_current_ref);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("throttle_filter_torque_map_tb: FAIL");
            $finish;
        end
    end

    task automatic hold_output(input int unsigned cycles);
        out_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        out_hold <= 1'b0;
    endtask

    // offer one sample, valid stays high into the next call when no gap is drawn
    task automatic send_sample(input logic [DW-1:0] raw);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= raw;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic apply_settings(input t_map_settings s);
        write_reg(CFG_BW_RISE, s.bw_rise);
        write_reg(CFG_BW_FALL, s.bw_fall);
        write_reg(CFG_ZERO_OFFSET, s.zero_offset);
        write_reg(CFG_FULL_SCALE, s.full_scale);
        write_reg(CFG_GAIN, s.gain);
        write_reg(CFG_GAIN_DIVISOR, s.gain_divisor);
        write_reg(CFG_RESPONSE_KIND, {{(DW-1){1'b0}}, s.response_kind});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // stop offering, let every awaited output arrive and the block go idle
    task automatic end_phase();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int unsigned in_pct, input int unsigned out_pct);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
    endtask

    function automatic t_map_settings make_settings(
        input logic [DW-1:0] rise, input logic [DW-1:0] fall,
        input logic [DW-1:0] offset, input logic [DW-1:0] scale,
        input logic signed [DW-1:0] slope, input logic [DW-1:0] slope_div,
        input logic kind);
        t_map_settings s;
        s.bw_rise       = rise;
        s.bw_fall       = fall;
        s.zero_offset   = offset;
        s.full_scale    = scale;
        s.gain          = slope;
        s.gain_divisor  = slope_div;
        s.response_kind = kind;
        return s;
    endfunction

    // divisor with zero and the top value now and then
    function automatic logic [DW-1:0] pick_divisor();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4, 5: return 16'($urandom_range(1, 8));
            6, 7:    return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic t_map_settings random_settings();
        t_map_settings s;
        s.bw_rise      = pick_divisor();
        s.bw_fall      = pick_divisor();
        s.gain_divisor = pick_divisor();
        case ($urandom_range(0, 7))
            0, 1, 2: s.zero_offset = 16'd0;
            3:       s.zero_offset = 16'hFFFF;
            4:       s.zero_offset = 16'($urandom_range(0, 65535));
            default: s.zero_offset = 16'($urandom_range(0, 4000));
        endcase
        case ($urandom_range(0, 7))
            0:       s.full_scale = 16'd0;
            1, 2:    s.full_scale = 16'hFFFF;
            3:       s.full_scale = 16'($urandom_range(1, 100));
            default: s.full_scale = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       s.gain = 16'sh8000;
            1:       s.gain = 16'sh7FFF;
            2:       s.gain = 16'sd0;
            3:       s.gain = -16'sd1;
            4, 5:    s.gain = 16'($urandom_range(1, 64));
            default: s.gain = 16'($urandom_range(0, 65535));
        endcase
        s.response_kind = $urandom_range(0, 1) ? RESP_STEP : RESP_LINEAR;
        return s;
    endfunction

    // mostly noisy samples around a slowly moving level so the average settles
    function automatic logic [DW-1:0] next_raw();
        int v;
        case ($urandom_range(0, 19))
            0, 1:          return INVALID_SAMPLE;
            2:             return 16'd0;
            3:             return 16'hFFFE;
            4, 5, 6, 7, 8: return 16'($urandom_range(0, 65535));
            default: begin
                v = int'(level_target) + int'($urandom_range(0, 2048)) - 1024;
                if (v < 0) v = 0;
                if (v > 65534) v = 65534;
                return 16'(v);
            end
        endcase
    endfunction

    // stimulus
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes of the sample and failed conversions
        set_idling(0, 0);
        send_sample(16'd0);
        send_sample(16'hFFFE);
        send_sample(INVALID_SAMPLE);
        send_sample(16'hFFFE);
        send_sample(INVALID_SAMPLE);
        send_sample(16'd1);
        send_sample(16'h8000);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'd0);
        end_phase();

        // zero divisors, zero full scale, offset floor, negative clamp
        apply_settings(make_settings(16'd0, 16'd0, 16'd1000, 16'd0,
                                     16'sh8000, 16'd0, RESP_LINEAR));
        set_idling(54, 0);
        send_sample(16'd500);
        send_sample(16'd1000);
        send_sample(INVALID_SAMPLE);
        send_sample(16'd1001);
        send_sample(16'd0);
        end_phase();

        // scaling overflow, slowest fall, positive extremes
        apply_settings(make_settings(16'd1, 16'hFFFF, 16'd0, 16'd1,
                                     16'sh7FFF, 16'hFFFF, RESP_LINEAR));
        set_idling(0, 54);
        send_sample(16'd3);
        send_sample(16'd0);
        send_sample(16'hFFFE);
        send_sample(INVALID_SAMPLE);
        send_sample(16'd0);
        send_sample(16'd7);
        end_phase();

        // step response on both sides of the threshold
        apply_settings(make_settings(16'd1, 16'd1, 16'd0, 16'hFFFF,
                                     16'sd1, 16'd1, RESP_STEP));
        set_idling(21, 21);
        send_sample(16'h7FFE);
        send_sample(16'h7FFF);
        send_sample(16'hFFFE);
        send_sample(16'd0);
        end_phase();

        // random settings, samples and idling
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(random_settings());
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(54, 0);
                2: set_idling(0, 54);
                default: set_idling(21, 21);
            endcase
            // fill the block while the output is held off
            if (p == 5) begin
                set_idling(0, 0);
                fork
                    hold_output(HOLD_CYCLES);
                join_none
            end
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 19) == 0) level_target = 16'($urandom_range(0, 65534));
                send_sample(next_raw());
            end
            end_phase();
        end

        $display("covered %0d samples (%0d failed conversions) under %0d register settings,",
                 board.samples_seen, board.failed_convs, settings_used + 1);
        $display("with mixed idling and a long output hold; %0d results compared, %0d bad",
                 board.results_checked, board.mismatches);
        if (board.mismatches == 0) begin
            $display("throttle_filter_torque_map_tb: PASS");
        end else begin
            $display("throttle_filter_torque_map_tb: FAIL");
        end
        $finish;
    end

endmodule
